// File: rtl/core/hbpwm_pkg.sv
// ----------------------------------------------------------------------------
// hbpwm_pkg
// Shared constants and types for the H-bridge PWM with dead time and brake.
// ----------------------------------------------------------------------------
package hbpwm_pkg;

    localparam int STEPS_PER_PERIOD_DEF = 100;

    localparam int DUTY_W  = 8;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 8;

    localparam logic [CFG_W-1:0] STEP_PRESCALE_RST = 16'd9;
    localparam logic [CFG_W-1:0] DEAD_TIME_RST     = 16'd1;

    typedef enum logic [INDEX_W-1:0] {
        REG_STEP_PRESCALE = 8'd0,
        REG_DEAD_TIME     = 8'd1
    } reg_index_t;

    typedef struct packed {
        logic braking;
        logic drive_b;
        logic drive_a;
    } drive_t;

endpackage

// File: rtl/core/hbpwm_core.sv
// ----------------------------------------------------------------------------
// hbpwm_core
// Prescaler, period step counter, dead-time and brake sequencing. Updates the
// bridge state on each accepted tick and presents the updated levels.
// ----------------------------------------------------------------------------
module hbpwm_core
    import hbpwm_pkg::*;
#(
    parameter int STEPS_PER_PERIOD = STEPS_PER_PERIOD_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tick,
    input  logic signed [DUTY_W-1:0] duty,
    input  logic                     brake_request,
    input  logic        [CFG_W-1:0]  step_prescale,
    input  logic        [CFG_W-1:0]  dead_time,
    output drive_t                   result
);

    localparam int STEP_W = $clog2(STEPS_PER_PERIOD + 1);
    localparam int CMP_W  = (STEP_W > DUTY_W) ? STEP_W : DUTY_W;
    localparam logic [STEP_W-1:0] STEP_END = STEP_W'(STEPS_PER_PERIOD);

    logic [CFG_W-1:0]  prescale_reg, prescale_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              brake_reg, brake_next;
    logic              level_a_reg, level_a_next;
    logic              level_b_reg, level_b_next;

    logic [DUTY_W-1:0] mag;
    logic              dir_neg;
    logic              dir_pos;
    logic [STEP_W-1:0] step_inc;
    logic              off_hit;

    always_comb
    begin
        if (brake_request)
        begin
            mag = '0;
        end
        else if (duty[DUTY_W-1])
        begin
            mag = ~duty + DUTY_W'(1);
        end
        else
        begin
            mag = duty;
        end
        dir_neg  = !brake_request && duty[DUTY_W-1];
        dir_pos  = !brake_request && !duty[DUTY_W-1] && (duty != '0);
        step_inc = step_reg + STEP_W'(1);
        off_hit  = (CMP_W'(step_inc) == CMP_W'(mag));
    end

    always_comb
    begin
        prescale_next = prescale_reg;
        step_next     = step_reg;
        brake_next    = brake_reg;
        level_a_next  = level_a_reg;
        level_b_next  = level_b_reg;
        if (tick)
        begin
            if (prescale_reg != '0)
            begin
                prescale_next = prescale_reg - CFG_W'(1);
            end
            else
            begin
                prescale_next = step_prescale;
                if (step_reg != STEP_END)
                begin
                    step_next = step_inc;
                    if (off_hit)
                    begin
                        level_a_next = 1'b0;
                        level_b_next = 1'b0;
                        brake_next   = 1'b0;
                    end
                    else if (brake_request && !brake_reg)
                    begin
                        if (level_a_reg || level_b_reg)
                        begin
                            prescale_next = dead_time;
                            level_a_next  = 1'b0;
                            level_b_next  = 1'b0;
                        end
                        else
                        begin
                            level_a_next = 1'b1;
                            level_b_next = 1'b1;
                            brake_next   = 1'b1;
                        end
                    end
                end
                else if (dir_neg)
                begin
                    if (level_a_reg)
                    begin
                        prescale_next = dead_time;
                        level_a_next  = 1'b0;
                        level_b_next  = 1'b0;
                    end
                    else
                    begin
                        level_a_next = 1'b0;
                        level_b_next = 1'b1;
                        step_next    = '0;
                    end
                    brake_next = 1'b0;
                end
                else if (dir_pos)
                begin
                    if (level_b_reg)
                    begin
                        prescale_next = dead_time;
                        level_a_next  = 1'b0;
                        level_b_next  = 1'b0;
                    end
                    else
                    begin
                        level_a_next = 1'b1;
                        level_b_next = 1'b0;
                        step_next    = '0;
                    end
                    brake_next = 1'b0;
                end
                else if (!brake_reg)
                begin
                    level_a_next = 1'b0;
                    level_b_next = 1'b0;
                end
                else
                begin
                    step_next = STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            step_reg     <= '0;
            brake_reg    <= 1'b0;
            level_a_reg  <= 1'b0;
            level_b_reg  <= 1'b0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            step_reg     <= step_next;
            brake_reg    <= brake_next;
            level_a_reg  <= level_a_next;
            level_b_reg  <= level_b_next;
        end
    end

    assign result.drive_a = level_a_next;
    assign result.drive_b = level_b_next;
    assign result.braking = brake_next;

    a_brake_both_high: assert property (@(posedge clk) disable iff (!rst_n)
        brake_reg == (level_a_reg && level_b_reg))
        else $error("brake state and bridge levels disagree");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_END)
        else $error("step count beyond period end");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> $stable(prescale_reg) && $stable(step_reg) && $stable(brake_reg))
        else $error("state moved without a tick");

endmodule

// File: rtl/core/h_bridge_pwm_dead_time.sv
// ----------------------------------------------------------------------------
// h_bridge_pwm_dead_time
// H-bridge PWM driver with prescaled period steps, dead time and brake.
//
//   channel  dir  handshake                  payload
//   s_axis   in   s_axis_tvalid/tready      tdata duty, tuser brake_request
//   m_axis   out  m_axis_tvalid/tready      tdata drive_a/drive_b, tuser braking
//   cfg      in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One tick accepted per clock while s_axis_tready is high; levels are registered
// in a two-entry buffer (out_reg, skid_reg); tready drops while skid_reg is full.
// cfg_ready is always high; unknown indexes are dropped.
// Reset: step_prescale 9, dead_time 1, counters and both drives low.
// ----------------------------------------------------------------------------
module h_bridge_pwm_dead_time
    import hbpwm_pkg::*;
#(
    parameter int STEPS_PER_PERIOD = STEPS_PER_PERIOD_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] duty
    input  logic               s_axis_tuser,   // [0] brake_request
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [0] drive_a, [1] drive_b
    output logic               m_axis_tuser,   // [0] braking
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    logic [CFG_W-1:0] step_prescale_reg;
    logic [CFG_W-1:0] dead_time_reg;

    logic   in_acc;
    logic   out_acc;
    drive_t result;
    drive_t out_reg;
    drive_t skid_reg;
    logic   out_valid_reg;
    logic   skid_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_prescale_reg <= STEP_PRESCALE_RST;
            dead_time_reg     <= DEAD_TIME_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_STEP_PRESCALE: step_prescale_reg <= cfg_data;
                REG_DEAD_TIME:     dead_time_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = out_valid_reg && m_axis_tready;

    hbpwm_core #(
        .STEPS_PER_PERIOD (STEPS_PER_PERIOD)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (in_acc),
        .duty          (signed'(s_axis_tdata)),
        .brake_request (s_axis_tuser),
        .step_prescale (step_prescale_reg),
        .dead_time     (dead_time_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_acc || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_acc || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_acc)
            begin
                out_reg <= result;
            end
        end
        else if (in_acc)
        begin
            skid_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg.drive_b, out_reg.drive_a};
    assign m_axis_tuser  = out_reg.braking;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a head entry");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("beat accepted under stall not buffered");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !in_acc && !skid_valid_reg) |=> !out_valid_reg)
        else $error("result repeated after delivery");

endmodule
